### design/lfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfx_pkg;

    localparam int LFX_MAX_LINE_DEF = 4096;
    localparam int OFS_W            = 13;
    localparam int STAMP_LEN        = 18;
    localparam int MIN_LINE         = 19;

    typedef logic [15:0] t_char;

    localparam t_char CH_TAB   = 16'h0009;
    localparam t_char CH_CR    = 16'h000D;
    localparam t_char CH_SPACE = 16'h0020;
    localparam t_char CH_PLUS  = 16'h002B;
    localparam t_char CH_MINUS = 16'h002D;
    localparam t_char CH_ZERO  = 16'h0030;
    localparam t_char CH_NINE  = 16'h0039;
    localparam t_char CH_COLON = 16'h003A;
    localparam t_char CH_V     = 16'h0056;
    localparam t_char CH_D     = 16'h0044;
    localparam t_char CH_I     = 16'h0049;
    localparam t_char CH_W     = 16'h0057;
    localparam t_char CH_E     = 16'h0045;
    localparam t_char CH_F     = 16'h0046;
    localparam t_char CH_S     = 16'h0053;

    typedef enum logic [2:0] {
        OUT_SHORT,
        OUT_PID_BAD,
        OUT_TID_BAD,
        OUT_NO_LEVEL,
        OUT_NO_COLON,
        OUT_COMPLETE
    } t_outcome;

    typedef struct packed {
        logic neg;
        logic digit;
        logic stop;
        logic ovf;
    } t_num_flags;

    typedef struct packed {
        t_char       char_code;
        logic        has_char;
        logic        end_of_line;
        logic [31:0] line_seq;
    } t_item;

    typedef struct packed {
        logic [31:0]      seq_out;
        t_outcome         outcome;
        logic [31:0]      pid_value;
        logic [31:0]      tid_value;
        logic [2:0]       level_code;
        logic [OFS_W-1:0] tag_start;
        logic [OFS_W-1:0] tag_end;
        logic [OFS_W-1:0] message_start;
        logic [OFS_W-1:0] line_length;
        logic             too_long;
    } t_result;

    function automatic logic is_ws(t_char c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

endpackage

`default_nettype wire

### design/lfx_digit.sv
`timescale 1ns / 1ps
`default_nettype none

module lfx_digit
    import lfx_pkg::*;
(
    input  logic [31:0] i_acc,
    input  t_num_flags  i_flags,
    input  t_char       i_char,
    input  logic        i_start,
    input  logic        i_feed,
    output logic [31:0] o_acc,
    output t_num_flags  o_flags
);

    logic [31:0] w_base_acc;
    t_num_flags  w_base_flags;
    logic [35:0] w_prod;
    logic        w_is_digit;
    logic        w_do_feed;

    always_comb begin
        w_base_acc   = (i_feed && i_start) ? '0 : i_acc;
        w_base_flags = (i_feed && i_start) ? '0 : i_flags;
        w_do_feed    = i_feed;
        if (i_feed && i_start && (i_char == CH_MINUS)) begin
            w_base_flags.neg = 1'b1;
            w_do_feed        = 1'b0;
        end else if (i_feed && i_start && (i_char == CH_PLUS)) begin
            w_do_feed = 1'b0;
        end
        w_is_digit = i_char inside {[CH_ZERO:CH_NINE]};
        // times ten as two shifted adds, plus the digit
        w_prod = 36'({w_base_acc, 3'b000}) + 36'({w_base_acc, 1'b0}) + 36'(i_char[3:0]);

        o_acc   = w_base_acc;
        o_flags = w_base_flags;
        if (w_do_feed && !w_base_flags.stop) begin
            if (w_is_digit) begin
                if (!w_base_flags.ovf) begin
                    if (|w_prod[35:32]) begin
                        o_flags.ovf = 1'b1;
                    end else begin
                        o_acc = w_prod[31:0];
                    end
                end
                o_flags.digit = 1'b1;
            end else begin
                o_flags.stop = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/lfx_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module lfx_parse
    import lfx_pkg::*;
#(
    parameter int MAX_LINE = LFX_MAX_LINE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam int POS_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;

    localparam logic [2:0] LV_UNKNOWN = 3'd0;
    localparam logic [2:0] LV_V       = 3'd1;
    localparam logic [2:0] LV_D       = 3'd2;
    localparam logic [2:0] LV_I       = 3'd3;
    localparam logic [2:0] LV_W       = 3'd4;
    localparam logic [2:0] LV_E       = 3'd5;
    localparam logic [2:0] LV_F       = 3'd6;
    localparam logic [2:0] LV_S       = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STAMP,
        PH_SKIP_PID,
        PH_PID,
        PH_SKIP_TID,
        PH_TID,
        PH_SKIP_LVL,
        PH_SKIP_TAG,
        PH_TAG,
        PH_COLON,
        PH_DONE,
        PH_BAD_PID,
        PH_BAD_TID
    } t_phase;

    function automatic logic [2:0] level_of(t_char c);
        case (c)
            CH_V:    return LV_V;
            CH_D:    return LV_D;
            CH_I:    return LV_I;
            CH_W:    return LV_W;
            CH_E:    return LV_E;
            CH_F:    return LV_F;
            CH_S:    return LV_S;
            default: return LV_UNKNOWN;
        endcase
    endfunction

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_pid, n_pid;
    logic [31:0]      r_tid, n_tid;
    t_num_flags       r_flags, n_flags;
    logic [2:0]       r_level, n_level;
    logic [OFS_W-1:0] r_tag_begin, n_tag_begin;
    logic [OFS_W-1:0] r_last_ns, n_last_ns;
    logic [OFS_W-1:0] r_msg, n_msg;
    logic [31:0]      r_seq, n_seq;
    logic             r_long, n_long;

    t_phase           w_p1;
    logic             w_take;
    logic             w_ws;
    logic             w_feed;
    logic             w_start;
    logic             w_pid_side;
    logic [31:0]      w_dig_acc;
    t_num_flags       w_dig_flags;
    logic [31:0]      w_closed;
    logic             w_close_ok;
    logic [OFS_W-1:0] w_ofs;
    logic [OFS_W-1:0] w_ofs_inc;

    always_comb begin
        w_take = i_item.has_char && (r_pos < POS_W'(MAX_LINE));
        w_p1   = (r_phase == PH_IDLE) ? PH_STAMP : r_phase;
        if (w_take && (r_pos >= POS_W'(STAMP_LEN)) && (w_p1 == PH_STAMP)) begin
            w_p1 = PH_SKIP_PID;
        end
        w_ws       = is_ws(i_item.char_code);
        w_start    = (w_p1 == PH_SKIP_PID) || (w_p1 == PH_SKIP_TID);
        w_pid_side = (w_p1 == PH_SKIP_PID) || (w_p1 == PH_PID);
        w_feed     = w_take && !w_ws && (w_start || (w_p1 == PH_PID) || (w_p1 == PH_TID));
        w_ofs      = r_pos[OFS_W-1:0];
        w_ofs_inc  = w_ofs + 1'b1;
    end

    lfx_digit u_digit (
        .i_acc   (w_pid_side ? r_pid : r_tid),
        .i_flags (r_flags),
        .i_char  (i_item.char_code),
        .i_start (w_start),
        .i_feed  (w_feed),
        .o_acc   (w_dig_acc),
        .o_flags (w_dig_flags)
    );

    assign w_closed   = w_dig_flags.neg ? (32'd0 - w_dig_acc) : w_dig_acc;
    assign w_close_ok = w_dig_flags.digit && !w_dig_flags.ovf;

    always_comb begin
        n_phase     = w_p1;
        n_pos       = w_take ? (r_pos + 1'b1) : r_pos;
        n_pid       = r_pid;
        n_tid       = r_tid;
        n_flags     = r_flags;
        n_level     = r_level;
        n_tag_begin = r_tag_begin;
        n_last_ns   = r_last_ns;
        n_msg       = r_msg;
        n_seq       = (r_phase == PH_IDLE) ? i_item.line_seq : r_seq;
        n_long      = r_long || (i_item.has_char && !w_take);

        if (w_take) begin
            case (w_p1)
                PH_SKIP_PID: begin
                    if (!w_ws) begin
                        n_pid   = w_dig_acc;
                        n_flags = w_dig_flags;
                        n_phase = PH_PID;
                    end
                end
                PH_PID: begin
                    if (w_ws) begin
                        if (w_close_ok) begin
                            n_pid   = w_closed;
                            n_phase = PH_SKIP_TID;
                        end else begin
                            n_phase = PH_BAD_PID;
                        end
                    end else begin
                        n_pid   = w_dig_acc;
                        n_flags = w_dig_flags;
                    end
                end
                PH_SKIP_TID: begin
                    if (!w_ws) begin
                        n_tid   = w_dig_acc;
                        n_flags = w_dig_flags;
                        n_phase = PH_TID;
                    end
                end
                PH_TID: begin
                    if (w_ws) begin
                        if (w_close_ok) begin
                            n_tid   = w_closed;
                            n_phase = PH_SKIP_LVL;
                        end else begin
                            n_phase = PH_BAD_TID;
                        end
                    end else begin
                        n_tid   = w_dig_acc;
                        n_flags = w_dig_flags;
                    end
                end
                PH_SKIP_LVL: begin
                    if (!w_ws) begin
                        n_level = level_of(i_item.char_code);
                        n_phase = PH_SKIP_TAG;
                    end
                end
                PH_SKIP_TAG: begin
                    if (!w_ws) begin
                        n_tag_begin = w_ofs;
                        if (i_item.char_code == CH_COLON) begin
                            n_last_ns = w_ofs;
                            n_msg     = w_ofs_inc;
                            n_phase   = PH_COLON;
                        end else begin
                            n_last_ns = w_ofs_inc;
                            n_phase   = PH_TAG;
                        end
                    end
                end
                PH_TAG: begin
                    if (i_item.char_code == CH_COLON) begin
                        n_msg   = w_ofs_inc;
                        n_phase = PH_COLON;
                    end else if (!w_ws) begin
                        n_last_ns = w_ofs_inc;
                    end
                end
                PH_COLON: begin
                    if (i_item.char_code == CH_SPACE) begin
                        n_msg = w_ofs_inc;
                    end
                    n_phase = PH_DONE;
                end
                default: begin
                end
            endcase
        end
    end

    // end-of-line result, taken from the state after this item's character
    always_comb begin
        o_result = '0;
        if (n_pos < POS_W'(MIN_LINE)) begin
            o_result.outcome = OUT_SHORT;
        end else begin
            case (n_phase)
                PH_PID:                   o_result.outcome = w_close_ok ? OUT_TID_BAD
                                                                        : OUT_PID_BAD;
                PH_TID:                   o_result.outcome = w_close_ok ? OUT_NO_LEVEL
                                                                        : OUT_TID_BAD;
                PH_SKIP_TID, PH_BAD_TID:  o_result.outcome = OUT_TID_BAD;
                PH_SKIP_LVL:              o_result.outcome = OUT_NO_LEVEL;
                PH_SKIP_TAG, PH_TAG:      o_result.outcome = OUT_NO_COLON;
                PH_COLON, PH_DONE:        o_result.outcome = OUT_COMPLETE;
                default:                  o_result.outcome = OUT_PID_BAD;
            endcase
        end
        if (o_result.outcome >= OUT_TID_BAD) begin
            o_result.pid_value = (n_phase == PH_PID) ? w_closed : n_pid;
        end
        if (o_result.outcome >= OUT_NO_LEVEL) begin
            o_result.tid_value = (n_phase == PH_TID) ? w_closed : n_tid;
        end
        if (o_result.outcome >= OUT_NO_COLON) begin
            o_result.level_code = n_level;
        end
        if (o_result.outcome == OUT_COMPLETE) begin
            o_result.tag_start     = n_tag_begin;
            o_result.tag_end       = n_last_ns;
            o_result.message_start = n_msg;
        end
        o_result.seq_out     = n_seq;
        o_result.line_length = n_pos[OFS_W-1:0];
        o_result.too_long    = n_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.end_of_line)) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_pid       <= '0;
            r_tid       <= '0;
            r_flags     <= '0;
            r_level     <= LV_UNKNOWN;
            r_tag_begin <= '0;
            r_last_ns   <= '0;
            r_msg       <= '0;
            r_seq       <= '0;
            r_long      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_pid       <= n_pid;
            r_tid       <= n_tid;
            r_flags     <= n_flags;
            r_level     <= n_level;
            r_tag_begin <= n_tag_begin;
            r_last_ns   <= n_last_ns;
            r_msg       <= n_msg;
            r_seq       <= n_seq;
            r_long      <= n_long;
        end
    end

endmodule

`default_nettype wire

### design/log_line_field_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    char_code, has_char, end_of_line, line_seq
// result    out        o_out_valid / i_out_ready  seq_out, outcome, pid/tid, level, offsets
//
// one item per cycle sustained, stalled only by a waiting end-of-line item; an item sits
// in the input register, is parsed into the line state, and an end-of-line item loads
// the result register; both registers lie between an input accept and result valid
// reset clears both valid flags and the line state
// an end-of-line item waits in the input register while the result register is full
// and not being taken; other items never stall

module log_line_field_extractor
    import lfx_pkg::*;
#(
    parameter int MAX_LINE = LFX_MAX_LINE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [15:0]      i_char_code,
    input  logic             i_has_char,
    input  logic             i_end_of_line,
    input  logic [31:0]      i_line_seq,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_seq_out,
    output logic [2:0]       o_outcome,
    output logic [31:0]      o_pid_value,
    output logic [31:0]      o_tid_value,
    output logic [2:0]       o_level_code,
    output logic [OFS_W-1:0] o_tag_start,
    output logic [OFS_W-1:0] o_tag_end,
    output logic [OFS_W-1:0] o_message_start,
    output logic [OFS_W-1:0] o_line_length,
    output logic             o_too_long
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_step;
    logic    w_load_out;
    t_result w_result;

    assign w_step     = r_in_valid && (!r_in.end_of_line || !r_out_valid || i_out_ready);
    assign w_load_out = w_step && r_in.end_of_line;
    assign o_in_ready = !r_in_valid || w_step;

    lfx_parse #(
        .MAX_LINE (MAX_LINE)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= '{char_code:   i_char_code,
                      has_char:    i_has_char,
                      end_of_line: i_end_of_line,
                      line_seq:    i_line_seq};
        end
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_seq_out       = r_out.seq_out;
    assign o_outcome       = r_out.outcome;
    assign o_pid_value     = r_out.pid_value;
    assign o_tid_value     = r_out.tid_value;
    assign o_level_code    = r_out.level_code;
    assign o_tag_start     = r_out.tag_start;
    assign o_tag_end       = r_out.tag_end;
    assign o_message_start = r_out.message_start;
    assign o_line_length   = r_out.line_length;
    assign o_too_long      = r_out.too_long;

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome <= OUT_COMPLETE))
        else $error("outcome code out of range");

    a_offsets_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome != OUT_COMPLETE)) |->
            (o_tag_start == '0 && o_tag_end == '0 && o_message_start == '0))
        else $error("offsets set on an incomplete line");

    a_short_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUT_SHORT)) |->
            (o_pid_value == '0 && o_tid_value == '0 && o_level_code == '0))
        else $error("short line carries parsed values");

    a_long_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_long) |-> (o_line_length == OFS_W'(MAX_LINE)))
        else $error("overlong line length not saturated");

endmodule

`default_nettype wire
